// ===== rtl/core/pngcd_pkg.sv =====
// ----------------------------------------------------------------------------
// pngcd_pkg
// Shared types, constants and the bytewise CRC-32 step for the PNG chunk
// deframer with CRC check.
// ----------------------------------------------------------------------------
package pngcd_pkg;

  // Field being read from the chunk stream
  typedef enum logic [1:0] {
    PH_LENGTH = 2'd0,
    PH_TYPE   = 2'd1,
    PH_DATA   = 2'd2,
    PH_CRC    = 2'd3
  } phase_e;

  // Result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Reflected CRC-32
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_XOUT = 32'hFFFF_FFFF;

  // Byte index of the last byte in a 4-byte field
  localparam logic [1:0] FIELD_LAST = 2'd3;

  // One result item
  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [31:0] chunk_length;
    logic [31:0] chunk_type;
    logic        ancillary_flag;
    logic        private_flag;
    logic        reserved_flag;
    logic        copy_safe_flag;
    logic [31:0] computed_crc;
    logic        crc_ok;
    logic        last_of_chunk;
  } result_t;

  // Advance the CRC by one byte, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/pngcd_if.sv =====
// ----------------------------------------------------------------------------
// pngcd_if
// Valid/ready channels: the byte stream in and the result stream out.
// ----------------------------------------------------------------------------
interface pngcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface pngcd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [31:0] chunk_length;
  logic [31:0] chunk_type;
  logic        ancillary_flag;
  logic        private_flag;
  logic        reserved_flag;
  logic        copy_safe_flag;
  logic [31:0] computed_crc;
  logic        crc_ok;
  logic        last_of_chunk;

  modport source (output valid, output kind, output payload_byte,
                  output chunk_length, output chunk_type,
                  output ancillary_flag, output private_flag,
                  output reserved_flag, output copy_safe_flag,
                  output computed_crc, output crc_ok, output last_of_chunk,
                  input ready);
  modport sink   (input valid, input kind, input payload_byte,
                  input chunk_length, input chunk_type,
                  input ancillary_flag, input private_flag,
                  input reserved_flag, input copy_safe_flag,
                  input computed_crc, input crc_ok, input last_of_chunk,
                  output ready);
endinterface

// ===== rtl/core/png_chunk_deframer_crc_check_core.sv =====
// ----------------------------------------------------------------------------
// png_chunk_deframer_crc_check_core
// PNG chunk deframer: splits a byte stream into length, type, data and CRC,
// passes data bytes through and reports each chunk with its CRC-32 check.
// ----------------------------------------------------------------------------
//   channel | dir | payload                                   | result per request
//   in_i    | in  | stream_byte                               | -
//   out_o   | out | kind, payload_byte, chunk fields, crc_ok  | 0 or 1
//
// One byte is taken per cycle; each byte is held in the input register and
// its result in the result register. The bytewise CRC-32 step and the
// 32-bit data counter sit between the two registers and set the cycle time.
// Reset clears the field sequencer and loads the CRC with all ones. A
// stalled sink stops the result register, and the input register then
// fills and drops in_i.ready.
// ----------------------------------------------------------------------------
module png_chunk_deframer_crc_check_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  pngcd_in_if.sink     in_i,
  pngcd_out_if.source  out_o
);

  logic               byte_valid;
  logic [7:0]         byte_val;
  logic               out_free;
  logic               take;
  logic               res_valid;
  pngcd_pkg::result_t res;

  // Take the held byte when the result register has room
  assign take = byte_valid && out_free;

  pngcd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .valid_o (byte_valid),
    .byte_o  (byte_val)
  );

  pngcd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .byte_i      (byte_val),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pngcd_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (take && res_valid),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (out_o)
  );

endmodule

// ===== rtl/core/pngcd_in_stage.sv =====
// ----------------------------------------------------------------------------
// pngcd_in_stage
// Input register: holds one stream byte until the parser takes it.
// ----------------------------------------------------------------------------
module pngcd_in_stage (
  input  logic        clk_i,
  input  logic        rst_ni,
  pngcd_in_if.sink    in_i,
  input  logic        take_i,
  output logic        valid_o,
  output logic [7:0]  byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       load;

  // Accept when empty or when the held byte leaves this cycle
  assign in_i.ready = !valid_q || take_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (load) begin
      valid_d = 1'b1;
      byte_d  = in_i.stream_byte;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== rtl/core/pngcd_parser.sv =====
// ----------------------------------------------------------------------------
// pngcd_parser
// Chunk field sequencer and CRC-32 accumulator; builds at most one result
// per byte taken.
// ----------------------------------------------------------------------------
module pngcd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          byte_i,
  output logic                res_valid_o,
  output pngcd_pkg::result_t  res_o
);

  pngcd_pkg::phase_e phase_q, phase_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [31:0]       len_q, len_d;
  logic [31:0]       rem_q, rem_d;
  logic [31:0]       type_q, type_d;
  logic [31:0]       crc_q, crc_d;
  logic [31:0]       rcv_q, rcv_d;
  logic [31:0]       crc_upd;
  logic [31:0]       crc_calc;
  logic              field_done;

  assign field_done = (cnt_q == pngcd_pkg::FIELD_LAST);
  assign crc_upd    = pngcd_pkg::crc_byte(crc_q, byte_i);
  assign crc_calc   = crc_q ^ pngcd_pkg::CRC_XOUT;

  // Next state and result for the byte at the parser input
  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    rem_d       = rem_q;
    type_d      = type_q;
    crc_d       = crc_q;
    rcv_d       = rcv_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (phase_q)
      pngcd_pkg::PH_LENGTH: begin
        len_d = {len_q[23:0], byte_i};
        cnt_d = cnt_q + 2'd1;
        if (field_done) begin
          phase_d = pngcd_pkg::PH_TYPE;
        end
      end
      pngcd_pkg::PH_TYPE: begin
        type_d = {type_q[23:0], byte_i};
        crc_d  = crc_upd;
        cnt_d  = cnt_q + 2'd1;
        if (field_done) begin
          rem_d   = len_q;
          phase_d = (len_q == 32'd0) ? pngcd_pkg::PH_CRC : pngcd_pkg::PH_DATA;
        end
      end
      pngcd_pkg::PH_DATA: begin
        crc_d = crc_upd;
        rem_d = rem_q - 32'd1;
        if (rem_q == 32'd1) begin
          phase_d = pngcd_pkg::PH_CRC;
        end
        res_valid_o        = 1'b1;
        res_o.kind         = pngcd_pkg::KIND_DATA;
        res_o.payload_byte = byte_i;
      end
      pngcd_pkg::PH_CRC: begin
        rcv_d = {rcv_q[23:0], byte_i};
        cnt_d = cnt_q + 2'd1;
        if (field_done) begin
          res_valid_o          = 1'b1;
          res_o.kind           = pngcd_pkg::KIND_END;
          res_o.chunk_length   = len_q;
          res_o.chunk_type     = type_q;
          res_o.ancillary_flag = type_q[29];
          res_o.private_flag   = type_q[21];
          res_o.reserved_flag  = type_q[13];
          res_o.copy_safe_flag = type_q[5];
          res_o.computed_crc   = crc_calc;
          res_o.crc_ok         = (rcv_d == crc_calc);
          res_o.last_of_chunk  = 1'b1;
          crc_d                = pngcd_pkg::CRC_INIT;
          phase_d              = pngcd_pkg::PH_LENGTH;
        end
      end
      default: begin
        phase_d = pngcd_pkg::PH_LENGTH;
      end
    endcase
  end

  // Advance state only on a byte taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pngcd_pkg::PH_LENGTH;
      cnt_q   <= 2'd0;
      len_q   <= 32'd0;
      rem_q   <= 32'd0;
      type_q  <= 32'd0;
      crc_q   <= pngcd_pkg::CRC_INIT;
      rcv_q   <= 32'd0;
    end else if (take_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      type_q  <= type_d;
      crc_q   <= crc_d;
      rcv_q   <= rcv_d;
    end
  end

endmodule

// ===== rtl/core/pngcd_out_stage.sv =====
// ----------------------------------------------------------------------------
// pngcd_out_stage
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module pngcd_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  pngcd_pkg::result_t  res_i,
  output logic                free_o,
  pngcd_out_if.source         out_o
);

  logic               valid_q, valid_d;
  pngcd_pkg::result_t res_q, res_d;

  // Room for a new result when empty or draining this cycle
  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Drive the channel from the held result
  assign out_o.valid          = valid_q;
  assign out_o.kind           = res_q.kind;
  assign out_o.payload_byte   = res_q.payload_byte;
  assign out_o.chunk_length   = res_q.chunk_length;
  assign out_o.chunk_type     = res_q.chunk_type;
  assign out_o.ancillary_flag = res_q.ancillary_flag;
  assign out_o.private_flag   = res_q.private_flag;
  assign out_o.reserved_flag  = res_q.reserved_flag;
  assign out_o.copy_safe_flag = res_q.copy_safe_flag;
  assign out_o.computed_crc   = res_q.computed_crc;
  assign out_o.crc_ok         = res_q.crc_ok;
  assign out_o.last_of_chunk  = res_q.last_of_chunk;

endmodule
